// ----- rtl/i2cmbs_pkg.sv -----
package i2cmbs_pkg;

  // command codes, same encoding as the operation field
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_t;

  // one classified request, as it travels from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       sda;
  } item_t;

  localparam logic [7:0] TICKS_RESET = 8'd50;
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  // phase numbers that matter to the sequencer
  localparam logic [5:0] PH_START_CHECK = 6'd1;
  localparam logic [5:0] PH_START_SDA_LO = 6'd2;
  localparam logic [5:0] PH_SHORT_LAST = 6'd3;
  localparam logic [5:0] PH_WR_DATA_END = 6'd24;
  localparam logic [5:0] PH_WR_ACK_REL = 6'd25;
  localparam logic [5:0] PH_WR_LAST = 6'd26;
  localparam logic [5:0] PH_RD_DATA_END = 6'd16;
  localparam logic [5:0] PH_RD_ACK_DRV = 6'd17;
  localparam logic [5:0] PH_RD_ACK_SCL = 6'd18;
  localparam logic [5:0] PH_RD_LAST = 6'd19;

  // sub step within a written bit
  localparam logic [1:0] SUB_SCL_LO = 2'd0;
  localparam logic [1:0] SUB_SDA_SET = 2'd1;
  localparam logic [1:0] SUB_SCL_HI = 2'd2;

endpackage

// ----- rtl/i2cmbs_front.sv -----
module i2cmbs_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_operation,
  input  logic [7:0]           in_tx_byte,
  input  logic                 in_sda_in,
  output logic                 push,
  output i2cmbs_pkg::item_t    push_item,
  input  logic                 queue_full
);
  import i2cmbs_pkg::*;

  cmd_t cmd;

  // classify the operation code, unknown codes become no command
  always_comb begin
    if (in_operation inside {[CMD_START:CMD_READ_NACK]}) begin
      cmd = cmd_t'(in_operation);
    end else begin
      cmd = CMD_NONE;
    end
  end

  // hand the request to the queue
  assign in_stall          = queue_full;
  assign push              = in_valid & ~queue_full;
  assign push_item.cmd     = cmd;
  assign push_item.tx_byte = in_tx_byte;
  assign push_item.sda     = in_sda_in;

endmodule

// ----- rtl/i2cmbs_fifo.sv -----
module i2cmbs_fifo #(
  parameter int unsigned DEPTH = i2cmbs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cmbs_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output i2cmbs_pkg::item_t pop_item,
  output logic              empty
);
  import i2cmbs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/i2cmbs_back.sv -----
module i2cmbs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        ticks_per_phase,
  input  logic              queue_empty,
  input  i2cmbs_pkg::item_t pop_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_scl_out,
  output logic              out_sda_out,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [7:0]        out_rx_byte,
  output logic              out_ack_seen,
  output logic              out_start_failed
);
  import i2cmbs_pkg::*;

  cmd_t        cmd_r, cmd_nxt;
  logic [5:0]  phase_r, phase_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_r, ack_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        fail_r, fail_nxt;
  logic        done_nxt;
  logic        out_valid_r;

  logic [7:0]  limit;
  logic [7:0]  cnt_inc;
  logic [5:0]  phase_inc;
  logic        busy;
  logic        launch;
  logic        phase_end;
  logic        finish;

  // take a request whenever the result register is free or draining
  assign pop = ~queue_empty & (~out_valid_r | ~out_stall);

  // step decode: tick limit, end of phase, end of command
  always_comb begin
    limit     = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
    cnt_inc   = cnt_r + 8'd1;
    phase_inc = phase_r + 6'd1;
    busy      = (cmd_r != CMD_NONE);
    launch    = ~busy & (pop_item.cmd != CMD_NONE);
    phase_end = busy & (cnt_inc >= limit);
    case (cmd_r)
      CMD_START:     finish = ((phase_r == PH_START_CHECK) && !pop_item.sda)
                              || (phase_r >= PH_SHORT_LAST);
      CMD_STOP:      finish = (phase_r >= PH_SHORT_LAST);
      CMD_WRITE:     finish = (phase_r >= PH_WR_LAST);
      CMD_READ_ACK,
      CMD_READ_NACK: finish = (phase_r >= PH_RD_LAST);
      default:       finish = 1'b0;
    endcase
  end

  // next state: command, phase, bit position, sub step, tick count
  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    sub_nxt   = sub_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    if (launch) begin
      cmd_nxt   = pop_item.cmd;
      phase_nxt = '0;
      bit_nxt   = '0;
      sub_nxt   = SUB_SCL_LO;
      cnt_nxt   = '0;
    end else if (busy) begin
      cnt_nxt = cnt_inc;
      if (phase_end) begin
        cnt_nxt = '0;
        if (finish) begin
          cmd_nxt   = CMD_NONE;
          phase_nxt = '0;
          bit_nxt   = '0;
          sub_nxt   = SUB_SCL_LO;
          done_nxt  = 1'b1;
        end else begin
          phase_nxt = phase_inc;
          if (cmd_r == CMD_WRITE && phase_inc < PH_WR_DATA_END) begin
            if (sub_r == SUB_SCL_HI) begin
              sub_nxt = SUB_SCL_LO;
              bit_nxt = bit_r + 3'd1;
            end else begin
              sub_nxt = sub_r + 2'd1;
            end
          end
        end
      end
    end
  end

  // line levels and data registers
  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    shift_nxt = shift_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    fail_nxt  = fail_r;
    if (launch) begin
      case (pop_item.cmd)
        CMD_START: begin
          fail_nxt = 1'b0;
          sda_nxt  = 1'b1;
        end
        CMD_STOP: begin
          scl_nxt = 1'b0;
        end
        CMD_WRITE: begin
          shift_nxt = pop_item.tx_byte;
          scl_nxt   = 1'b0;
        end
        default: begin
          shift_nxt = '0;
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b0;
        end
      endcase
    end else if (phase_end) begin
      if (finish) begin
        case (cmd_r)
          CMD_START: begin
            if (phase_r == PH_START_CHECK && !pop_item.sda) begin
              fail_nxt = 1'b1;
            end
          end
          CMD_WRITE: begin
            ack_nxt = ~pop_item.sda;
            scl_nxt = 1'b0;
          end
          CMD_READ_ACK, CMD_READ_NACK: begin
            rx_nxt = shift_r;
          end
          default: begin
          end
        endcase
      end else begin
        case (cmd_r)
          CMD_START: begin
            if (phase_inc == PH_START_CHECK) begin
              scl_nxt = 1'b1;
            end else if (phase_inc == PH_START_SDA_LO) begin
              sda_nxt = 1'b0;
            end else begin
              scl_nxt = 1'b0;
            end
          end
          CMD_STOP: begin
            if (phase_inc == 6'd1) begin
              sda_nxt = 1'b0;
            end else if (phase_inc == 6'd2) begin
              scl_nxt = 1'b1;
            end else begin
              sda_nxt = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase_inc < PH_WR_DATA_END) begin
              case (sub_nxt)
                SUB_SCL_LO:  scl_nxt = 1'b0;
                SUB_SDA_SET: sda_nxt = shift_r[~bit_nxt];
                default:     scl_nxt = 1'b1;
              endcase
            end else if (phase_inc == PH_WR_DATA_END) begin
              scl_nxt = 1'b0;
            end else if (phase_inc == PH_WR_ACK_REL) begin
              sda_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b1;
            end
          end
          default: begin
            // sample on the end of each high half of a data bit
            if (phase_r < PH_RD_DATA_END && phase_r[0]) begin
              shift_nxt = {shift_r[6:0], pop_item.sda};
            end
            if (phase_inc < PH_RD_DATA_END) begin
              scl_nxt = phase_inc[0];
            end else if (phase_inc == PH_RD_DATA_END) begin
              scl_nxt = 1'b0;
            end else if (phase_inc == PH_RD_ACK_DRV) begin
              sda_nxt = (cmd_r == CMD_READ_ACK) ? 1'b0 : 1'b1;
            end else if (phase_inc == PH_RD_ACK_SCL) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_NONE;
      phase_r <= '0;
      bit_r   <= '0;
      sub_r   <= SUB_SCL_LO;
      cnt_r   <= '0;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      rx_r    <= '0;
      fail_r  <= 1'b0;
    end else if (pop) begin
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      sub_r   <= sub_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_scl_out      <= scl_nxt;
      out_sda_out      <= sda_nxt;
      out_busy_res     <= (cmd_nxt != CMD_NONE);
      out_done_res     <= done_nxt;
      out_rx_byte      <= rx_nxt;
      out_ack_seen     <= ack_nxt;
      out_start_failed <= fail_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/i2c_master_bit_sequencer.sv -----
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_stall   | in_operation, in_tx_byte, in_sda_in
// out_     | output    | out_valid / out_stall | out_scl_out, out_sda_out, out_busy_res,
//          |           |                       | out_done_res, out_rx_byte, out_ack_seen,
//          |           |                       | out_start_failed
// cfg_     | input     | cfg_wr_en             | cfg_wr_data (ticks per phase)
//
// one request per cycle sustained while out_stall is low; a result is presented once the
// request is written into the queue, handed on by it and loaded into the result register.
// the back end performs one tick of the line sequencer per request taken from the queue.
// reset (rst_n low, synchronous) releases both lines, idles the sequencer, empties the queue
// and loads 50 ticks per phase.
// a stalled result holds; requests keep entering until the queue is full, then in_stall rises.
module i2c_master_bit_sequencer #(
  parameter int unsigned QUEUE_DEPTH = i2cmbs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_ack_seen,
  output logic       out_start_failed,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import i2cmbs_pkg::*;

  logic [7:0] ticks_r;
  logic       push;
  item_t      push_item;
  logic       queue_full;
  logic       pop;
  item_t      pop_item;
  logic       queue_empty;

  // ticks per phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
    end else if (cfg_wr_en) begin
      ticks_r <= cfg_wr_data;
    end
  end

  // request classification
  i2cmbs_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_tx_byte   (in_tx_byte),
    .in_sda_in    (in_sda_in),
    .push         (push),
    .push_item    (push_item),
    .queue_full   (queue_full)
  );

  // request queue
  i2cmbs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (queue_empty)
  );

  // line sequencer and result register
  i2cmbs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .ticks_per_phase  (ticks_r),
    .queue_empty      (queue_empty),
    .pop_item         (pop_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_rx_byte      (out_rx_byte),
    .out_ack_seen     (out_ack_seen),
    .out_start_failed (out_start_failed)
  );

endmodule
